### rtl/dtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared codes, types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int TimeW  = 32;
   localparam int MaxOut = 16;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] KIND_ADDED   = 2'd0;
   localparam logic [1:0] KIND_EXPIRED = 2'd1;
   localparam logic [1:0] KIND_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [TimeW-1:0] arg;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CANCEL,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

### rtl/dtq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_front
// Accepts items, drops unknown ops, selects the operand and queues commands.
// ----------------------------------------------------------------------------
module dtq_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [95:0]             req_tdata,
   input  logic [1:0]              req_tuser,
   output dtq_pkg::queue_head_type head,
   input  logic                    pop
);

   dtq_pkg::cmd_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   dtq_pkg::cmd_type cmd;
   logic             push;

   always_comb begin
      cmd.op = req_tuser;
      unique case (req_tuser)
         dtq_pkg::OP_ADD:    cmd.arg = req_tdata[31:0];
         dtq_pkg::OP_CANCEL: cmd.arg = req_tdata[63:32];
         default:            cmd.arg = req_tdata[95:64];
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready && (req_tuser != dtq_pkg::OP_UNUSED);
   assign head.valid = (cnt_ff != 2'd0);
   assign head.cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

### rtl/dtq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_back
// Holds the packed timer table and carries out add, cancel and tick commands.
// ----------------------------------------------------------------------------
module dtq_back #(
   parameter int CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dtq_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = $clog2(dtq_pkg::MaxOut + 1);

   logic [31:0] dl_ff [CAPACITY];
   logic [31:0] id_ff [CAPACITY];

   dtq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [31:0]   time_ff, time_in;
   logic [31:0]   idc_ff, idc_in;
   logic [31:0]   arg_ff, arg_in;
   logic [IW-1:0] best_ff, best_in;
   logic [31:0]   best_dl_ff, best_dl_in;
   logic          found_ff, found_in;
   logic [31:0]   pend_ff, pend_in;
   logic          have_pend_ff, have_pend_in;
   logic [EW-1:0] emit_ff, emit_in;
   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_kind_ff, out_kind_in;
   logic [31:0]   out_id_ff, out_id_in;
   logic          out_last_ff, out_last_in;

   logic          out_free;
   logic          wr_en, rm_en;
   logic [IW-1:0] rm_idx;
   logic [32:0]   sum;
   logic [31:0]   new_dl;
   logic [31:0]   cur_dl, cur_id;

   assign out_free = !out_valid_ff || rsp_tready;
   assign sum = {1'b0, time_ff} + {1'b0, head.cmd.arg};
   assign new_dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign cur_dl = dl_ff[idx_ff[IW-1:0]];
   assign cur_id = id_ff[idx_ff[IW-1:0]];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      time_in = time_ff;
      idc_in = idc_ff;
      arg_in = arg_ff;
      best_in = best_ff;
      best_dl_in = best_dl_ff;
      found_in = found_ff;
      pend_in = pend_ff;
      have_pend_in = have_pend_ff;
      emit_in = emit_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in = out_kind_ff;
      out_id_in = out_id_ff;
      out_last_in = out_last_ff;
      pop = 1'b0;
      wr_en = 1'b0;
      rm_en = 1'b0;
      rm_idx = idx_ff[IW-1:0];
      unique case (state_ff)
         dtq_pkg::ST_IDLE: begin
            if (head.valid) begin
               priority if (head.cmd.op == dtq_pkg::OP_ADD) begin
                  if (out_free) begin
                     pop = 1'b1;
                     out_valid_in = 1'b1;
                     out_last_in = 1'b1;
                     if (count_ff == CW'(CAPACITY)) begin
                        out_kind_in = dtq_pkg::KIND_FULL;
                        out_id_in = 32'd0;
                     end else begin
                        wr_en = 1'b1;
                        count_in = count_ff + CW'(1);
                        idc_in = idc_ff + 32'd1;
                        out_kind_in = dtq_pkg::KIND_ADDED;
                        out_id_in = idc_ff + 32'd1;
                     end
                  end
               end else if (head.cmd.op == dtq_pkg::OP_CANCEL) begin
                  pop = 1'b1;
                  arg_in = head.cmd.arg;
                  idx_in = '0;
                  state_in = dtq_pkg::ST_CANCEL;
               end else begin
                  pop = 1'b1;
                  arg_in = head.cmd.arg;
                  time_in = head.cmd.arg;
                  idx_in = '0;
                  found_in = 1'b0;
                  have_pend_in = 1'b0;
                  emit_in = '0;
                  state_in = dtq_pkg::ST_SCAN;
               end
            end
         end
         dtq_pkg::ST_CANCEL: begin
            if (idx_ff == count_ff) begin
               state_in = dtq_pkg::ST_IDLE;
            end else if (cur_id == arg_ff) begin
               rm_en = 1'b1;
               count_in = count_ff - CW'(1);
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         dtq_pkg::ST_SCAN: begin
            if (idx_ff == count_ff) begin
               if (found_ff) begin
                  if (!have_pend_ff || out_free) begin
                     if (have_pend_ff) begin
                        out_valid_in = 1'b1;
                        out_kind_in = dtq_pkg::KIND_EXPIRED;
                        out_id_in = pend_ff;
                        out_last_in = 1'b0;
                     end
                     pend_in = id_ff[best_ff];
                     have_pend_in = 1'b1;
                     rm_en = 1'b1;
                     rm_idx = best_ff;
                     count_in = count_ff - CW'(1);
                     emit_in = emit_ff + EW'(1);
                     idx_in = '0;
                     found_in = 1'b0;
                     if (emit_ff == EW'(dtq_pkg::MaxOut - 1)) begin
                        state_in = dtq_pkg::ST_FLUSH;
                     end
                  end
               end else if (have_pend_ff) begin
                  state_in = dtq_pkg::ST_FLUSH;
               end else begin
                  state_in = dtq_pkg::ST_IDLE;
               end
            end else begin
               if (cur_dl <= arg_ff && (!found_ff || cur_dl < best_dl_ff)) begin
                  found_in = 1'b1;
                  best_in = idx_ff[IW-1:0];
                  best_dl_in = cur_dl;
               end
               idx_in = idx_ff + CW'(1);
            end
         end
         dtq_pkg::ST_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in = dtq_pkg::KIND_EXPIRED;
               out_id_in = pend_ff;
               out_last_in = 1'b1;
               state_in = dtq_pkg::ST_IDLE;
            end
         end
         default: state_in = dtq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtq_pkg::ST_IDLE;
         count_ff <= '0;
         time_ff <= 32'd0;
         idc_ff <= 32'd0;
         out_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         have_pend_ff <= 1'b0;
         emit_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         time_ff <= time_in;
         idc_ff <= idc_in;
         out_valid_ff <= out_valid_in;
         found_ff <= found_in;
         have_pend_ff <= have_pend_in;
         emit_ff <= emit_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      arg_ff <= arg_in;
      best_ff <= best_in;
      best_dl_ff <= best_dl_in;
      pend_ff <= pend_in;
      out_kind_ff <= out_kind_in;
      out_id_ff <= out_id_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (rm_en && IW'(i) >= rm_idx && i < CAPACITY - 1) begin
            dl_ff[i] <= dl_ff[i + 1];
            id_ff[i] <= id_ff[i + 1];
         end else if (wr_en && IW'(i) == count_ff[IW-1:0]) begin
            dl_ff[i] <= new_dl;
            id_ff[i] <= idc_ff + 32'd1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_id_ff;
   assign rsp_tuser = out_kind_ff;
   assign rsp_tlast = out_last_ff;

endmodule

### rtl/deadline_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue
// One-shot deadline timer table with add, cancel and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser carries the op (add, cancel, tick); tdata carries
//   delay, cancel id and now. Unknown ops are accepted and dropped.
//   rsp channel: tuser carries the kind (added, expired, full), tdata the
//   task id, tlast marks the final result of one command.
//   A two-entry command queue decouples the request side from the engine.
//   Add: the result is registered, one add per cycle unless the receiver stalls.
//   Cancel: one table entry per cycle, no result.
//   Tick: a dispatch step, then one pass over the live entries per
//   expired task, plus one final pass unless 16 fired, and a flush step
//   for the last item; at most 16 tasks fire per tick.
//   The sequential scan of the table sets the rate of ticks and cancels.
//   Reset empties the table and clears time and the id counter.
//   A stalled receiver holds the engine; the command queue then fills and
//   req_tready drops.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // delay[31:0], cancel_id[63:32], now[95:64]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // task_id[31:0]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);

   dtq_pkg::queue_head_type head;
   logic                    pop;

   dtq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   dtq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/dtq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks of the deadline timer queue.
// ----------------------------------------------------------------------------
module dtq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_full_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dtq_pkg::KIND_FULL |-> rsp_tdata == 32'd0 && rsp_tlast)
      else $error("table full item malformed");

   a_added_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dtq_pkg::KIND_ADDED |-> rsp_tlast && rsp_tdata != 32'd0)
      else $error("added item malformed");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
